[rtl/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths and character codes for the signed integer to decimal ASCII
// converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

  // number of decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
  function automatic int calc_digits(input int bits);
    longint unsigned v;
    int              n;
    begin
      v = 64'd1 << (bits - 1);
      n = 0;
      for (int i = 0; i < 24; i++) begin
        if (v != 64'd0) begin
          n++;
          v = v / 10;
        end
      end
      return n;
    end
  endfunction

  localparam int NUM_DIGITS = calc_digits(VALUE_BITS);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  localparam int CHAR_W      = 6;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);

endpackage

[rtl/itoa_dabble.sv]
// ----------------------------------------------------------------------------
// itoa_dabble
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module itoa_dabble
  import itoa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [VALUE_BITS-1:0]     mag_in,
  output logic                      done,
  output logic [BCD_W-1:0]          bcd
);

  logic                  run_r,  run_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic [VALUE_BITS-1:0] bin_r,  bin_nxt;
  logic [BCD_W-1:0]      bcd_r,  bcd_nxt;
  logic [BCD_W-1:0]      adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(VALUE_BITS);
      bin_nxt = mag_in;
      bcd_nxt = '0;
    end else if (run_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed integer per item into its decimal ASCII text, most
// significant character first, with tlast on the final character.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tlast
//  in_     | in  | [31:0] value (signed)         | -
//  out_    | out | [5:0] char_code, [7:6] zero   | last_char
//
//  Per item: an accept, the bit-serial shift/add-3 conversion of the
//  VALUE_BITS (32) bit magnitude, a hand-over, then a minus sign if the value
//  is negative and each digit position in turn (leading zeros skipped, the rest emitted).
//  in_tready is high only while idle; the output register lets the next item
//  be taken while the last character still waits. out_tready stalls emission.
//  Reset (rst_n, synchronous) returns to idle with no item pending.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [itoa_pkg::IN_TDATA_W-1:0] in_tdata,   // [31:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [itoa_pkg::OUT_TDATA_W-1:0] out_tdata, // [5:0] char_code
  output logic                            out_tlast   // last_char
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t                state_r, state_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic                  lead_done_r, lead_done_nxt;
  logic [DIG_IDX_W-1:0]  idx_r, idx_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0]     ochar_r, ochar_nxt;
  logic                  olast_r, olast_nxt;

  logic                  in_acc;
  logic                  push_ok;
  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  dab_done;
  logic [BCD_W-1:0]      bcd;
  logic [3:0]            dig;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign raw       = in_tdata[VALUE_BITS-1:0];
  assign neg       = raw[VALUE_BITS-1];
  assign mag       = neg ? (~raw + VALUE_BITS'(1)) : raw;
  assign push_ok   = !ovalid_r || out_tready;
  assign dig       = bcd[4*idx_r +: 4];

  itoa_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .mag_in (mag),
    .done   (dab_done),
    .bcd    (bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    sign_pend_nxt = sign_pend_r;
    lead_done_nxt = lead_done_r;
    idx_nxt       = idx_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    ochar_nxt     = ochar_r;
    olast_nxt     = olast_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt     = S_CONV;
          sign_pend_nxt = neg;
        end
      end
      S_CONV: begin
        if (dab_done) begin
          state_nxt     = S_EMIT;
          idx_nxt       = DIG_IDX_W'(NUM_DIGITS - 1);
          lead_done_nxt = 1'b0;
        end
      end
      S_EMIT: begin
        if (sign_pend_r) begin
          if (push_ok) begin
            ovalid_nxt    = 1'b1;
            ochar_nxt     = CH_MINUS;
            olast_nxt     = 1'b0;
            sign_pend_nxt = 1'b0;
          end
        end else if (!lead_done_r && dig == 4'd0 && idx_r != '0) begin
          idx_nxt = idx_r - DIG_IDX_W'(1);
        end else if (push_ok) begin
          ovalid_nxt    = 1'b1;
          ochar_nxt     = CH_ZERO + CHAR_W'(dig);
          olast_nxt     = (idx_r == '0);
          lead_done_nxt = 1'b1;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - DIG_IDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sign_pend_r <= 1'b0;
      lead_done_r <= 1'b0;
      idx_r       <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_pend_r <= sign_pend_nxt;
      lead_done_r <= lead_done_nxt;
      idx_r       <= idx_nxt;
      ovalid_r    <= ovalid_nxt;
    end
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {(OUT_TDATA_W - CHAR_W)'(0), ochar_r};
  assign out_tlast  = olast_r;

  // busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted twice without conversion");

  // minus sign never closes the text
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ochar_r == CH_MINUS) |-> !olast_r)
    else $error("minus sign marked last");

  // only '-' or digits leave
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ochar_r == CH_MINUS || (ochar_r >= CH_ZERO &&
                  ochar_r <= CH_ZERO + CHAR_W'(9))))
    else $error("bad character code");

  // sign is emitted before returning to idle
  a_idle_no_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sign_pend_r)
    else $error("sign pending while idle");

endmodule

[tb/sv/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed integer to decimal ASCII converter.
// A directed table covers zero, the signs, digit-count boundaries and both
// extremes. Random values follow in three flow-control phases. Every value
// accepted on in_ is expanded here into its expected character sequence, and
// each character leaving on out_ is checked against it in order.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
  import itoa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PER_PHASE = 36;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } ascii_char_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    string                        text;   // empty: use the predictor
  } num_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  ascii_char_t char_q[$];
  int          mismatches;
  int          cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;
  num_row_t    num_rows[21];

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // expected decimal text: optional minus, digits MSD first, last flag on final
  function automatic void push_decimal(logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[$];
    logic                  neg;
    ascii_char_t           ch;
    neg = value[VALUE_BITS-1];
    mag = neg ? (~value + 1'b1) : value;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      ch.code = CH_MINUS;
      ch.is_last = 1'b0;
      char_q.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = CH_ZERO + CHAR_W'(digits[i]);
      ch.is_last = (i == digits.size() - 1);
      char_q.push_back(ch);
    end
  endfunction

  function automatic void push_text(string text);
    ascii_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.code = CHAR_W'(text[i]);
      ch.is_last = (i == text.len() - 1);
      char_q.push_back(ch);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    longint                p;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = VALUE_BITS'($urandom_range(0, 999));
      2: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = VALUE_BITS'(p + $urandom_range(0, 2) - 1);
      end
      3: begin
        if ($urandom_range(0, 1))
          v = {1'b1, {(VALUE_BITS-1){1'b0}}} + VALUE_BITS'($urandom_range(0, 3));
        else
          v = {1'b0, {(VALUE_BITS-1){1'b1}}} - VALUE_BITS'($urandom_range(0, 3));
        return v;
      end
      default: v = VALUE_BITS'($urandom()) >> $urandom_range(0, VALUE_BITS - 1);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_number(logic [VALUE_BITS-1:0] value, string text);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(value);
    do @(posedge clk); while (!in_tready);
    if (text.len() != 0) push_text(text);
    else push_decimal(value);
  endtask

  task automatic wait_all_chars();
    in_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (char_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected char: tdata %0d last %0b", out_tdata, out_tlast);
      end else begin
        want = char_q.pop_front();
        if (out_tdata[CHAR_W-1:0] !== want.code || out_tlast !== want.is_last ||
            out_tdata[OUT_TDATA_W-1:CHAR_W] !== '0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("char mismatch: expected code %0d last %0b, got tdata %0d last %0b",
                     want.code, want.is_last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_idle_pct = 27;
    rx_idle_pct = 64;
    num_rows = '{
      '{32'sd0,            "0"},
      '{32'sd1,            "1"},
      '{-32'sd1,           "-1"},
      '{32'sh7FFF_FFFF,    "2147483647"},
      '{32'sh8000_0000,    "-2147483648"},
      '{32'sh8000_0001,    ""},
      '{32'sd7,            ""},
      '{32'sd9,            ""},
      '{32'sd10,           ""},
      '{-32'sd9,           ""},
      '{-32'sd10,          ""},
      '{32'sd99,           ""},
      '{32'sd100,          ""},
      '{-32'sd100,         ""},
      '{32'sd999999999,    ""},
      '{32'sd1000000000,   ""},
      '{-32'sd1000000000,  ""},
      '{32'sd12345,        ""},
      '{-32'sd987654321,   ""},
      '{32'sh5555_5555,    ""},
      '{32'shAAAA_AAAA,    ""}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (num_rows[i]) send_number(num_rows[i].value, num_rows[i].text);
    wait_all_chars();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 64 : 0;
      rx_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 27 : 0;
      repeat (RAND_PER_PHASE) send_number(pick_value(), "");
      wait_all_chars();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
